// ===== hw/rtl/pwfd_pkg.sv =====
// Package for the pulse-width frame decoder.
// Holds field widths, register reset values and register index codes.
// No dependencies.
package pwfd_pkg;

	localparam int unsigned LevelW  = 1;
	localparam int unsigned DelayW  = 8;
	localparam int unsigned PauseW  = 10;
	localparam int unsigned FbitsW  = 6;
	localparam int unsigned WordW   = 32;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 10;

	localparam logic [DelayW-1:0] DelayReset = 8'd26;
	localparam logic [PauseW-1:0] PauseReset = 10'd256;
	localparam logic [FbitsW-1:0] FbitsReset = 6'd18;

	// Tick counter saturates here.
	localparam logic [PauseW-1:0] CountMax = 10'd1023;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_SAMPLE_DELAY = 2'd0,
		CFG_PAUSE_TICKS  = 2'd1,
		CFG_FRAME_BITS   = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_idx_t;

endpackage

// ===== hw/rtl/pulse_width_frame_decoder_core.sv =====
// Pulse-width frame decoder top level.
// Depends on pwfd_pkg.
//
// Usage:
//   Feed one line sample per prescaled timer tick on the input channel
//   (in_valid/in_stall, line_level). A rising edge of the line restarts an
//   internal tick counter; sample_delay ticks later the line level is
//   shifted in as the next frame bit. After frame_bits bits a frame_word is
//   sent on the output channel (out_valid/out_stall). If pause_ticks ticks
//   pass without an edge, the partial frame is dropped.
//   Registers are written on the cfg channel (cfg_valid/cfg_ready, index
//   and data); cfg_ready is always high. Write them only while idle.
// Timing:
//   One tick per clock while nothing stalls. A tick is captured in the input
//   register and decoded from there, where it may wait on a stall; a finished
//   frame is written to the output register as its last tick is decoded.
// Reset clears all decode state and loads the register defaults
//   (delay 26, pause 256, frame 18 bits). When the receiver stalls, ticks
//   that finish no frame keep flowing; a tick that would finish a frame
//   waits in the input register until the output slot frees up.
module pulse_width_frame_decoder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pwfd_pkg::LevelW-1:0]       line_level,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pwfd_pkg::WordW-1:0]        frame_word,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pwfd_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [pwfd_pkg::CfgDataW-1:0]     cfg_data
);

	// Configuration registers
	logic [pwfd_pkg::DelayW-1:0] sample_delay_q;
	logic [pwfd_pkg::PauseW-1:0] pause_ticks_q;
	logic [pwfd_pkg::FbitsW-1:0] frame_bits_q;

	// Input register
	logic                        valid_s1;
	logic [pwfd_pkg::LevelW-1:0] level_s1;

	// Decode state
	logic                        last_level_q;
	logic                        running_q;
	logic                        pending_q;
	logic [pwfd_pkg::PauseW-1:0] tick_q;
	logic [pwfd_pkg::WordW-1:0]  shift_q;
	logic [pwfd_pkg::FbitsW-1:0] bits_q;

	// Output register
	logic                        out_valid_q;
	logic [pwfd_pkg::WordW-1:0]  word_q;

	// Next-state logic
	logic                        rise;
	logic [pwfd_pkg::PauseW-1:0] tick_inc;
	logic                        take_sample;
	logic [pwfd_pkg::WordW-1:0]  shifted;
	logic [pwfd_pkg::FbitsW-1:0] bits_inc;
	logic                        emit;
	logic                        pause_hit;
	logic                        slot_free;
	logic                        advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_delay_q <= pwfd_pkg::DelayReset;
			pause_ticks_q  <= pwfd_pkg::PauseReset;
			frame_bits_q   <= pwfd_pkg::FbitsReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pwfd_pkg::cfg_idx_t'(cfg_index))
				pwfd_pkg::CFG_SAMPLE_DELAY: sample_delay_q <= cfg_data[pwfd_pkg::DelayW-1:0];
				pwfd_pkg::CFG_PAUSE_TICKS:  pause_ticks_q  <= cfg_data[pwfd_pkg::PauseW-1:0];
				pwfd_pkg::CFG_FRAME_BITS:   frame_bits_q   <= cfg_data[pwfd_pkg::FbitsW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rise        = level_s1[0] && !last_level_q;
		tick_inc    = (tick_q < pwfd_pkg::CountMax) ? tick_q + 1'b1 : tick_q;
		take_sample = !rise && running_q && pending_q
			&& (tick_inc == {2'b00, sample_delay_q});
		shifted     = {shift_q[pwfd_pkg::WordW-2:0], level_s1[0]};
		bits_inc    = bits_q + 1'b1;
		emit        = take_sample && (bits_inc == frame_bits_q);
		pause_hit   = !rise && running_q && (tick_inc == pause_ticks_q);
		slot_free   = !out_valid_q || !out_stall;
		// Hold the tick only when it finishes a frame and the slot is taken.
		advance     = valid_s1 && (!emit || slot_free);
		in_stall    = valid_s1 && !advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			level_s1 <= line_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
			running_q    <= 1'b0;
			pending_q    <= 1'b0;
			tick_q       <= '0;
			shift_q      <= '0;
			bits_q       <= '0;
		end else if (advance) begin
			last_level_q <= level_s1[0];
			if (rise) begin
				tick_q    <= '0;
				running_q <= 1'b1;
				pending_q <= 1'b1;
			end else if (running_q) begin
				tick_q <= tick_inc;
				if (pause_hit) begin
					// Drop the partial frame and stop the counter.
					shift_q   <= '0;
					bits_q    <= '0;
					running_q <= 1'b0;
					pending_q <= 1'b0;
				end else if (take_sample) begin
					pending_q <= 1'b0;
					if (emit) begin
						shift_q <= '0;
						bits_q  <= '0;
					end else begin
						shift_q <= shifted;
						bits_q  <= bits_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			word_q <= shifted;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_word = word_q;

endmodule

// ===== bench/pulse_width_frame_decoder_core_test.sv =====
`timescale 1ns / 1ps
// Testbench for pulse_width_frame_decoder_core: pulse trains in, frame words out.
// Depends on pwfd_pkg and the core; a scoreboard class predicts every frame.
module pulse_width_frame_decoder_core_test;
	import pwfd_pkg::*;

	localparam int QuietLimit = 2000;
	localparam int RandomTicks = 200;
	localparam int RandomFrames = 12;

	class frame_board;
		logic [DelayW-1:0] delay;
		logic [PauseW-1:0] pause;
		logic [FbitsW-1:0] nbits;
		logic              prev_level;
		logic              running;
		logic              armed;
		logic [PauseW-1:0] ticks;
		logic [WordW-1:0]  word;
		logic [FbitsW-1:0] nbit;
		logic [WordW-1:0]  pending[$];
		int                errors;
		int                ticks_seen;
		int                frames_due;
		int                frames_seen;

		function new();
			delay = DelayReset;
			pause = PauseReset;
			nbits = FbitsReset;
			prev_level = 1'b0;
			running = 1'b0;
			armed = 1'b0;
			ticks = '0;
			word = '0;
			nbit = '0;
			errors = 0;
			ticks_seen = 0;
			frames_due = 0;
			frames_seen = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CfgDataW-1:0] data);
			case (idx)
				CFG_SAMPLE_DELAY: delay = data[DelayW-1:0];
				CFG_PAUSE_TICKS:  pause = data[PauseW-1:0];
				CFG_FRAME_BITS:   nbits = data[FbitsW-1:0];
				default: ;
			endcase
		endfunction

		function void note_tick(logic level);
			ticks_seen++;
			if (level && !prev_level) begin
				ticks = '0;
				running = 1'b1;
				armed = 1'b1;
			end else if (running) begin
				if (ticks != CountMax)
					ticks = ticks + 1'b1;
				if (armed && ticks == {2'b00, delay}) begin
					armed = 1'b0;
					word = {word[WordW-2:0], level};
					nbit = nbit + 1'b1;
					if (nbit == nbits) begin
						pending.push_back(word);
						frames_due++;
						word = '0;
						nbit = '0;
					end
				end
				// pause discards whatever the sample left behind
				if (ticks == pause) begin
					word = '0;
					nbit = '0;
					running = 1'b0;
					armed = 1'b0;
				end
			end
			prev_level = level;
		endfunction

		function void check_frame(logic [WordW-1:0] got);
			logic [WordW-1:0] want;
			frames_seen++;
			if (pending.size() == 0) begin
				$display("%0t: frame_word %h arrived with none due", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: frame_word mismatch, expected %h, actual %h", $time, want, got);
				errors++;
			end
		endfunction

		function void flush();
			while (pending.size() != 0) begin
				$display("%0t: frame_word %h expected but never arrived", $time,
					pending.pop_front());
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [LevelW-1:0]   line_level = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [WordW-1:0]    frame_word;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = CFG_SAMPLE_DELAY;
	logic [CfgDataW-1:0] cfg_data = '0;

	frame_board board = new();
	bit calm = 1'b0;
	bit idle_on = 1'b1;
	bit stall_on = 1'b1;
	bit hold_off = 1'b0;
	int quiet = 0;
	int settings = 0;

	pulse_width_frame_decoder_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.line_level (line_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_word (frame_word),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Everything settles by the falling edge; check transfers there.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_frame(frame_word);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet == QuietLimit) begin
				$display("%0t: watchdog, no transfer for %0d cycles", $time, QuietLimit);
				$display("FAIL");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (250) @(posedge clk);
				out_stall <= 1'b0;
				hold_off = 1'b0;
			end else if (!calm && stall_on && $urandom_range(4, 0) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(5, 1)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_tick(input logic lvl);
		if (!calm && idle_on && $urandom_range(6, 0) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		line_level <= lvl;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		board.note_tick(lvl);
		@(posedge clk);
	endtask

	// One pulse: long high for a one, short high for a zero, then low; with a zero sample delay the high length is random.
	task automatic send_bit(input logic b);
		int d;
		int p;
		int h;
		d = board.delay;
		if (d == 0) begin
			h = $urandom_range(3, 1);
			p = h + $urandom_range(3, 1);
		end else begin
			p = d + 2 + $urandom_range(2, 0);
			if (board.pause != 0 && board.pause > p && board.pause <= d + 40
					&& $urandom_range(9, 0) == 0)
				p = board.pause;
			h = b ? $urandom_range(p - 1, d + 1) : $urandom_range(d, 1);
		end
		repeat (h) send_tick(1'b1);
		repeat (p - h) send_tick(1'b0);
	endtask

	task automatic send_frame(input logic [63:0] bits, input int n);
		for (int i = n - 1; i >= 0; i--)
			send_bit(bits[i]);
	endtask

	// Hold the line low past the pause to drop any partial frame; a zero or
	// long pause is not waited out.
	task automatic resync();
		if (board.pause == 0 || board.pause > 64)
			repeat (4) send_tick(1'b0);
		else
			repeat (board.pause + 2) send_tick(1'b0);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		board.set_reg(idx, data);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int d, input int p, input int f);
		logic [CfgDataW-1:0] v;
		settle();
		v = CfgDataW'($urandom);
		v[DelayW-1:0] = DelayW'(d);
		write_reg(CFG_SAMPLE_DELAY, v);
		write_reg(CFG_PAUSE_TICKS, CfgDataW'(p));
		v = CfgDataW'($urandom);
		v[FbitsW-1:0] = FbitsW'(f);
		write_reg(CFG_FRAME_BITS, v);
		if ($urandom_range(2, 0) == 0)
			write_reg(CFG_UNUSED, CfgDataW'($urandom));
		settings++;
	endtask

	function automatic int frame_len();
		return (board.nbits == 0) ? 64 : board.nbits;
	endfunction

	initial begin
		int start_ticks;
		int start_frames;
		int d;
		int n;
		int r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Frame length and pause at their reset values.
		write_reg(CFG_SAMPLE_DELAY, CfgDataW'(2));
		send_frame(64'h2AAAA, 18);

		configure(1, 1023, 32);
		send_frame(64'h8000_0001, 32);

		configure(1, 2, 1);
		repeat (6) send_bit(1'($urandom));
		resync();

		// Zero sample delay: nothing is ever sampled.
		configure(0, 20, 2);
		send_frame(64'hF, 4);
		resync();

		// Zero pause: the timer never stops, so the frame survives a long gap.
		configure(4, 0, 3);
		send_frame(64'h2, 2);
		repeat (30) send_tick(1'b0);
		send_bit(1'b1);

		// Zero frame bits means 64; only the last 32 bits remain.
		configure(1, 12, 0);
		send_frame({$urandom, $urandom}, 64);

		// Long receiver hold-off with one-bit frames fills the core.
		configure(1, 6, 1);
		hold_off = 1'b1;
		repeat (20) send_bit(1'($urandom));

		start_ticks = board.ticks_seen;
		start_frames = board.frames_due;
		while (board.ticks_seen - start_ticks < RandomTicks
				|| board.frames_due - start_frames < RandomFrames) begin
			calm = (board.ticks_seen - start_ticks >= RandomTicks - 60);
			idle_on = ($urandom_range(3, 0) != 0);
			stall_on = ($urandom_range(3, 0) != 0);
			if ($urandom_range(9, 0) == 0) begin
				d = $urandom_range(20, 1);
				configure(d, ($urandom_range(3, 0) == 0) ? 1023 : d + 6 + $urandom_range(20, 0),
					$urandom_range(3, 1));
				n = 1;
			end else begin
				d = $urandom_range(6, 1);
				configure(d, ($urandom_range(7, 0) == 0) ? 0 : d + 6 + $urandom_range(10, 0),
					$urandom_range(6, 1));
				n = $urandom_range(5, 2);
			end
			repeat (n) begin
				r = $urandom_range(9, 0);
				if (r == 0) begin
					send_frame({$urandom, $urandom}, $urandom_range(frame_len(), 1));
					resync();
				end else if (r == 1) begin
					repeat ($urandom_range(30, 3)) send_tick(1'($urandom));
					send_tick(1'b0);
					resync();
				end else begin
					send_frame({$urandom, $urandom}, frame_len());
					if ($urandom_range(3, 0) == 0)
						resync();
				end
			end
		end

		settle();
		repeat (8) @(posedge clk);
		board.flush();
		$display("Covered %0d line ticks over %0d register settings;", board.ticks_seen, settings);
		$display("%0d frames predicted, %0d received, %0d mismatches.", board.frames_due,
			board.frames_seen, board.errors);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/pwfd_pkg.sv
hw/rtl/pulse_width_frame_decoder_core.sv
bench/pulse_width_frame_decoder_core_test.sv
